FILE: hw/rtl/bmp24_to_rgb565_placer_core_macros.svh
// ----------------------------------------------------------------------------
// BMP placer assertion macros
// Clocked on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef BMP24_TO_RGB565_PLACER_CORE_MACROS_SVH
`define BMP24_TO_RGB565_PLACER_CORE_MACROS_SVH

// Same-cycle implication.
`define BMPP_ASSERT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define BMPP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/bmpp_pkg.sv
// ----------------------------------------------------------------------------
// BMP placer package
// Result word layout, result kinds and queue sizing shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package bmpp_pkg;

   localparam int COORD_W    = 11;
   localparam int COLOR_W    = 16;
   localparam int KIND_W     = 2;
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

   localparam logic [KIND_W-1:0] KIND_PIXEL  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DONE   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;
   localparam logic [KIND_W-1:0] KIND_EARLY  = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
      logic [COLOR_W-1:0] color565;
      logic               run_last;
   } result_type;

endpackage

`default_nettype wire

FILE: hw/rtl/bmpp_fifo.sv
// ----------------------------------------------------------------------------
// BMP placer result queue
// Small queue: up to two words in per cycle if room, one out per ready cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bmp24_to_rgb565_placer_core_macros.svh"

module bmpp_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           push_cnt,
   input  bmpp_pkg::result_type push0,
   input  bmpp_pkg::result_type push1,
   output logic                 room,
   output logic                 out_valid,
   input  logic                 out_ready,
   output bmpp_pkg::result_type out_data
);
   import bmpp_pkg::*;

   result_type       queue_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] wr_ptr_nx;
   logic             pop;

   assign out_valid = (count_ff != '0);
   assign out_data  = queue_ff[rd_ptr_ff];
   assign room      = (count_ff <= CNT_W'(FIFO_DEPTH - 2));
   assign pop       = out_valid && out_ready;
   assign wr_ptr_nx = wr_ptr_ff + PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_cnt);
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push_cnt) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push_cnt != 2'd0) begin
         queue_ff[wr_ptr_ff] <= push0;
      end
      if (push_cnt == 2'd2) begin
         queue_ff[wr_ptr_nx] <= push1;
      end
   end

   `BMPP_ASSERT(a_fifo_bound, 1'b1, count_ff <= CNT_W'(FIFO_DEPTH), "result queue overfilled")
   `BMPP_ASSERT(a_fifo_push_room, push_cnt != 2'd0, room, "result pushed without room")

endmodule

`default_nettype wire

FILE: hw/rtl/bmpp_decode.sv
// ----------------------------------------------------------------------------
// BMP placer byte decoder
// Header capture and check, placement, row skipping and RGB565 packing.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bmp24_to_rgb565_placer_core_macros.svh"

module bmpp_decode #(
   parameter int SCREEN_W    = 128,
   parameter int SCREEN_H    = 160,
   parameter int MAX_IMAGE_W = 1280
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           step_byte,
   input  logic                 step_eof,
   output logic [1:0]           push_cnt,
   output bmpp_pkg::result_type push0,
   output bmpp_pkg::result_type push1
);
   import bmpp_pkg::*;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_GAP,
      PH_PIXELS,
      PH_DONE,
      PH_REJECT
   } phase_type;

   localparam int POS_OFFSET = 10;
   localparam int POS_WIDTH  = 18;
   localparam int POS_HEIGHT = 22;
   localparam int POS_CHECK  = 26;
   localparam int POS_LAST   = 33;
   localparam logic [7:0]  PLANES_ONE = 8'd1;
   localparam logic [7:0]  BITS_24    = 8'd24;
   localparam logic [11:0] SW12       = 12'(SCREEN_W);
   localparam logic [11:0] SH12       = 12'(SCREEN_H);
   localparam logic [11:0] MAXW12     = 12'(MAX_IMAGE_W);

   logic [31:0]        pos_ff, pos_in;
   phase_type          phase_ff, phase_in;
   logic [31:0]        offset_ff, offset_in;
   logic [11:0]        width_ff, width_in;
   logic               width_hi_ff, width_hi_in;
   logic [15:0]        height_ff, height_in;
   logic               height_hi_ff, height_hi_in;
   logic               check_ok_ff, check_ok_in;
   logic [12:0]        stride_ff, stride_in;
   logic [11:0]        kept3_ff, kept3_in;
   logic [COORD_W-1:0] col_start_ff, col_start_in;
   logic [15:0]        skip_ff, skip_in;
   logic [COORD_W-1:0] rows_left_ff, rows_left_in;
   logic [12:0]        bir_ff, bir_in;
   logic [1:0]         tri_ff, tri_in;
   logic [10:0]        partial_ff, partial_in;
   logic [COORD_W-1:0] cur_x_ff, cur_x_in;
   logic [COORD_W-1:0] cur_y_ff, cur_y_in;

   logic [11:0]        kw;
   logic [11:0]        ye12;
   logic [12:0]        bir_inc;
   logic               hsmall;
   logic               hdr_ok;
   logic               run_pix;
   logic               finish;
   logic               pix;
   result_type         pix_word;
   result_type         stat_word;

   // header derived values
   always_comb begin
      kw     = (width_ff > SW12) ? SW12 : width_ff;
      hsmall = (height_ff <= 16'(SCREEN_H));
      ye12   = hsmall ? ((SH12 - height_ff[11:0]) >> 1) + height_ff[11:0] - 12'd1
                      : SH12 - 12'd1;
      hdr_ok = check_ok_ff && (step_byte == 8'd0) && !width_hi_ff && (width_ff != '0) &&
               (width_ff <= MAXW12) && !height_hi_ff && (height_ff != '0) &&
               (height_ff != 16'hFFFF) && (offset_ff >= 32'(POS_LAST + 1));
      bir_inc = bir_ff + 13'd1;
   end

   always_comb begin
      pos_in       = pos_ff;
      phase_in     = phase_ff;
      offset_in    = offset_ff;
      width_in     = width_ff;
      width_hi_in  = width_hi_ff;
      height_in    = height_ff;
      height_hi_in = height_hi_ff;
      check_ok_in  = check_ok_ff;
      stride_in    = stride_ff;
      kept3_in     = kept3_ff;
      col_start_in = col_start_ff;
      skip_in      = skip_ff;
      rows_left_in = rows_left_ff;
      bir_in       = bir_ff;
      tri_in       = tri_ff;
      partial_in   = partial_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      run_pix      = 1'b0;
      finish       = 1'b0;
      pix          = 1'b0;
      pix_word     = '0;
      stat_word    = '0;
      push_cnt     = 2'd0;
      push0        = '0;
      push1        = '0;

      if (step) begin
         pos_in = (pos_ff == '1) ? pos_ff : pos_ff + 32'd1;

         unique case (phase_ff)
            PH_HEADER: begin
               case (pos_ff[5:0])
                  6'(POS_OFFSET):     offset_in[7:0]   = step_byte;
                  6'(POS_OFFSET + 1): offset_in[15:8]  = step_byte;
                  6'(POS_OFFSET + 2): offset_in[23:16] = step_byte;
                  6'(POS_OFFSET + 3): offset_in[31:24] = step_byte;
                  6'(POS_WIDTH): width_in[7:0] = step_byte;
                  6'(POS_WIDTH + 1): begin
                     width_in[11:8] = step_byte[3:0];
                     width_hi_in    = (step_byte[7:4] != 4'd0);
                  end
                  6'(POS_WIDTH + 2),
                  6'(POS_WIDTH + 3): width_hi_in = width_hi_ff || (step_byte != 8'd0);
                  6'(POS_HEIGHT):     height_in[7:0]  = step_byte;
                  6'(POS_HEIGHT + 1): height_in[15:8] = step_byte;
                  6'(POS_HEIGHT + 2): height_hi_in = (step_byte != 8'd0);
                  6'(POS_HEIGHT + 3): height_hi_in = height_hi_ff || (step_byte != 8'd0);
                  6'(POS_CHECK):      check_ok_in = (step_byte == PLANES_ONE);
                  6'(POS_CHECK + 2):  check_ok_in = check_ok_ff && (step_byte == BITS_24);
                  6'(POS_CHECK + 1),
                  6'(POS_CHECK + 3),
                  6'(POS_CHECK + 4),
                  6'(POS_CHECK + 5),
                  6'(POS_CHECK + 6):  check_ok_in = check_ok_ff && (step_byte == 8'd0);
                  6'(POS_LAST): begin
                     if (hdr_ok) begin
                        phase_in     = PH_GAP;
                        stride_in    = ({width_ff, 1'b0} + {1'b0, width_ff} + 13'd3) &
                                       ~13'd3;
                        kept3_in     = 12'({kw, 1'b0} + {1'b0, kw});
                        col_start_in = (width_ff > SW12) ? '0
                                       : COORD_W'((SW12 - width_ff) >> 1);
                        skip_in      = hsmall ? 16'd0 : height_ff - 16'(SCREEN_H);
                        rows_left_in = hsmall ? height_ff[COORD_W-1:0]
                                              : COORD_W'(SCREEN_H);
                        cur_x_in     = (width_ff > SW12) ? '0
                                       : COORD_W'((SW12 - width_ff) >> 1);
                        cur_y_in     = ye12[COORD_W-1:0];
                        bir_in       = '0;
                        tri_in       = '0;
                        partial_in   = '0;
                     end else begin
                        phase_in = PH_REJECT;
                     end
                  end
                  default: ;
               endcase
            end
            PH_GAP: begin
               if (pos_ff >= offset_ff) begin
                  phase_in = PH_PIXELS;
                  run_pix  = 1'b1;
               end
            end
            PH_PIXELS: run_pix = 1'b1;
            PH_DONE, PH_REJECT: ;
            default: ;
         endcase

         if (run_pix) begin
            if (skip_ff != '0) begin
               if (bir_inc >= stride_ff) begin
                  bir_in  = '0;
                  skip_in = skip_ff - 16'd1;
               end else begin
                  bir_in = bir_inc;
               end
            end else begin
               if (bir_ff < {1'b0, kept3_ff}) begin
                  case (tri_ff)
                     2'd0: partial_in = {6'd0, step_byte[7:3]};
                     2'd1: partial_in = {step_byte[7:2], partial_ff[4:0]};
                     default: begin
                        pix              = 1'b1;
                        pix_word.kind    = KIND_PIXEL;
                        pix_word.pixel_x = cur_x_ff;
                        pix_word.pixel_y = cur_y_ff;
                        pix_word.color565 = {step_byte[7:3], partial_ff};
                        cur_x_in         = cur_x_ff + COORD_W'(1);
                        if ((bir_inc == {1'b0, kept3_ff}) &&
                            (rows_left_ff <= COORD_W'(1))) begin
                           rows_left_in = '0;
                           phase_in     = PH_DONE;
                           finish       = 1'b1;
                        end
                     end
                  endcase
               end
               if (!finish) begin
                  tri_in = (tri_ff == 2'd2) ? 2'd0 : tri_ff + 2'd1;
                  if (bir_inc >= stride_ff) begin
                     bir_in   = '0;
                     tri_in   = '0;
                     cur_y_in = cur_y_ff - COORD_W'(1);
                     cur_x_in = col_start_ff;
                     if (rows_left_ff != '0) begin
                        rows_left_in = rows_left_ff - COORD_W'(1);
                     end
                  end else begin
                     bir_in = bir_inc;
                  end
               end
            end
         end

         if (step_eof) begin
            unique case (phase_in)
               PH_DONE:   stat_word.kind = KIND_DONE;
               PH_REJECT: stat_word.kind = KIND_REJECT;
               default:   stat_word.kind = KIND_EARLY;
            endcase
            stat_word.run_last = 1'b1;
            pos_in             = '0;
            phase_in           = PH_HEADER;
         end

         if (pix && step_eof) begin
            push_cnt = 2'd2;
            push0    = pix_word;
            push1    = stat_word;
         end else if (pix) begin
            push_cnt       = 2'd1;
            push0          = pix_word;
            push0.run_last = 1'b1;
         end else if (step_eof) begin
            push_cnt = 2'd1;
            push0    = stat_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         phase_ff <= PH_HEADER;
      end else begin
         pos_ff   <= pos_in;
         phase_ff <= phase_in;
      end
      offset_ff    <= offset_in;
      width_ff     <= width_in;
      width_hi_ff  <= width_hi_in;
      height_ff    <= height_in;
      height_hi_ff <= height_hi_in;
      check_ok_ff  <= check_ok_in;
      stride_ff    <= stride_in;
      kept3_ff     <= kept3_in;
      col_start_ff <= col_start_in;
      skip_ff      <= skip_in;
      rows_left_ff <= rows_left_in;
      bir_ff       <= bir_in;
      tri_ff       <= tri_in;
      partial_ff   <= partial_in;
      cur_x_ff     <= cur_x_in;
      cur_y_ff     <= cur_y_in;
   end

   `BMPP_ASSERT_NEXT(a_eof_restart, step && step_eof, (pos_ff == '0) && (phase_ff == PH_HEADER), "file end did not restart decoder")
   `BMPP_ASSERT(a_pair_order, push_cnt == 2'd2, (push0.kind == KIND_PIXEL) && !push0.run_last && (push1.kind != KIND_PIXEL) && push1.run_last, "bad result pair")
   `BMPP_ASSERT(a_done_quiet, step && ((phase_ff == PH_DONE) || (phase_ff == PH_REJECT)), (push_cnt == 2'd0) || ((push_cnt == 2'd1) && (push0.kind != KIND_PIXEL)), "pixel after image end")

endmodule

`default_nettype wire

FILE: hw/rtl/bmp24_to_rgb565_placer_core.sv
// ----------------------------------------------------------------------------
// BMP 24-bit to RGB565 placer
// Streams a 24-bit BMP file byte by byte and emits placed RGB565 pixels.
// ----------------------------------------------------------------------------
// Input words (req_*) carry one file byte each, req_end_of_file on the last.
// Output words (rsp_*) are pixels (kind 0, with screen x,y and color) or one
// status word per file (image done, header rejected, file ended early) given
// on the last byte; rsp_run_last marks the final word caused by a byte.
// A byte accepted on the input is registered in a hold stage, decoded into
// the four-entry result queue once that queue has room, and its first word
// then shows on rsp_valid.
// Throughput: one byte per cycle while the queue has room. A byte that ends
// the file and also completes the last pixel gives two words.
// The input side is gated by queue space (room for two words), so with a
// stalled receiver req_ready goes low once the queue lacks that room; nothing
// is dropped. Reset clears the queue and returns the decoder to the header.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp24_to_rgb565_placer_core #(
   parameter int SCREEN_W    = 128,
   parameter int SCREEN_H    = 160,
   parameter int MAX_IMAGE_W = 1280
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_data_byte,
   input  logic                           req_end_of_file,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [bmpp_pkg::KIND_W-1:0]    rsp_kind,
   output logic [bmpp_pkg::COORD_W-1:0]   rsp_pixel_x,
   output logic [bmpp_pkg::COORD_W-1:0]   rsp_pixel_y,
   output logic [bmpp_pkg::COLOR_W-1:0]   rsp_color565,
   output logic                           rsp_run_last
);
   import bmpp_pkg::*;

   logic       hold_valid_ff, hold_valid_in;
   logic [7:0] hold_byte_ff, hold_byte_in;
   logic       hold_eof_ff, hold_eof_in;
   logic       advance;
   logic       room;
   logic [1:0] push_cnt;
   result_type push0;
   result_type push1;
   result_type out_data;

   assign advance   = hold_valid_ff && room;
   assign req_ready = !hold_valid_ff || advance;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_byte_in  = hold_byte_ff;
      hold_eof_in   = hold_eof_ff;
      if (req_ready) begin
         hold_valid_in = req_valid;
         hold_byte_in  = req_data_byte;
         hold_eof_in   = req_end_of_file;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_byte_ff <= hold_byte_in;
      hold_eof_ff  <= hold_eof_in;
   end

   bmpp_decode #(
      .SCREEN_W    (SCREEN_W),
      .SCREEN_H    (SCREEN_H),
      .MAX_IMAGE_W (MAX_IMAGE_W)
   ) u_decode (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .step_byte (hold_byte_ff),
      .step_eof  (hold_eof_ff),
      .push_cnt  (push_cnt),
      .push0     (push0),
      .push1     (push1)
   );

   bmpp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_cnt  (push_cnt),
      .push0     (push0),
      .push1     (push1),
      .room      (room),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (out_data)
   );

   assign rsp_kind     = out_data.kind;
   assign rsp_pixel_x  = out_data.pixel_x;
   assign rsp_pixel_y  = out_data.pixel_y;
   assign rsp_color565 = out_data.color565;
   assign rsp_run_last = out_data.run_last;

endmodule

`default_nettype wire
